// ----- rtl/sorted_key_table_find_insert_assert.svh -----
// Assertion macros shared by the sorted key table checker
`ifndef SORTED_KEY_TABLE_FIND_INSERT_ASSERT_SVH
`define SORTED_KEY_TABLE_FIND_INSERT_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// Package for the sorted key table: constants, state and cell control types
package skt_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W        = 64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WAIT,
    S_RES
  } state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
  } cell_ctrl_t;

endpackage

// ----- rtl/sorted_key_table_find_insert.sv -----
// Sorted key table with lookup and find-or-insert, built as a row of key cells
//
// Input channel (in_valid/in_ready): func selects lookup (0) or find-or-insert (1),
// vaddr is the 64-bit key. Output channel (out_valid/out_ready) returns hit,
// inserted, full_res, position and entry_count, one result per transaction.
// All cells compare the key at once; a registered tree of clog2(CAPACITY)
// levels then finds the first slot not below the key and any exact match.
// From input acceptance a key passes the compare flags, the tree's leaf
// register and each tree level, then the output register; one transaction
// is in flight at a time, so a new one waits until the last result is loaded.
// An insert writes the key and shifts every later cell up by one together.
// A new transaction is accepted while a finished result still waits in the
// output register; if the receiver stalls, the next result holds in its last
// step until the output register is free.
// Reset empties the table (count zero) and drops any pending result; key cells
// are not cleared, as slots at or above the count are never read.
module sorted_key_table_find_insert import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [KEY_W-1:0] vaddr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             hit,
  output logic             inserted,
  output logic             full_res,
  output logic [CW-1:0]    position,
  output logic [CW-1:0]    entry_count
);

  localparam int LVL = $clog2(CAPACITY);
  localparam int WCW = $clog2(LVL + 1);

  state_t                          state, state_next;
  cell_ctrl_t                      ctrl;
  logic [WCW-1:0]                  wcnt;
  logic                            func_r;
  logic [KEY_W-1:0]                key_r;
  logic [CW-1:0]                   count;
  logic [CAPACITY-1:0][KEY_W-1:0]  keys;
  logic [CAPACITY-1:0]             ge;
  logic [CAPACITY-1:0]             eq;
  logic                            root_any;
  logic                            root_hit;
  logic [CW-1:0]                   root_idx;
  logic [CW-1:0]                   pos_w;
  logic                            miss_ins;
  logic                            full_w;
  logic                            do_ins;
  logic                            res_load;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] key_prev;
    logic             ge_prev;
    if (i == 0) begin : g_head
      assign key_prev = '0;
      assign ge_prev  = 1'b0;
    end else begin : g_link
      assign key_prev = keys[i-1];
      assign ge_prev  = ge[i-1];
    end
    skt_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .pos      (pos_w),
      .key_req  (key_r),
      .key_prev (key_prev),
      .ge_prev  (ge_prev),
      .key      (keys[i]),
      .ge       (ge[i]),
      .eq       (eq[i])
    );
  end

  skt_tree #(.N(CAPACITY), .CW(CW)) u_tree (
    .clk      (clk),
    .ge       (ge),
    .eq       (eq),
    .root_any (root_any),
    .root_hit (root_hit),
    .root_idx (root_idx)
  );

  assign pos_w    = root_any ? root_idx : count;
  assign miss_ins = func_r & ~root_hit;
  assign full_w   = miss_ins & (count == CW'(CAPACITY));
  assign do_ins   = miss_ins & ~full_w;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp   = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (wcnt == WCW'(LVL)) begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid || out_ready) begin
          res_load   = 1'b1;
          ctrl.ins   = do_ins;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wcnt      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_WAIT) begin
        wcnt <= wcnt + 1'b1;
      end else begin
        wcnt <= '0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
        if (do_ins) begin
          count <= count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= func;
      key_r  <= vaddr;
    end
    if (res_load) begin
      hit         <= root_hit;
      inserted    <= do_ins;
      full_res    <= full_w;
      position    <= pos_w;
      entry_count <= do_ins ? count + 1'b1 : count;
    end
  end

endmodule

// ----- rtl/skt_cell.sv -----
// One slot of the sorted key table: key register, compare flags, shift-up path
module skt_cell import skt_pkg::*; #(
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CW-1:0]    count,
  input  logic [CW-1:0]    pos,
  input  logic [KEY_W-1:0] key_req,
  input  logic [KEY_W-1:0] key_prev,
  input  logic             ge_prev,
  output logic [KEY_W-1:0] key,
  output logic             ge,
  output logic             eq
);

  logic occupied;
  logic at_pos;

  assign occupied = CW'(IDX) < count;
  assign at_pos   = CW'(IDX) == pos;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      ge <= occupied && (key >= key_req);
      eq <= occupied && (key == key_req);
    end
    if (ctrl.ins) begin
      if (at_pos) begin
        key <= key_req;
      end else if (ge_prev) begin
        key <= key_prev;
      end
    end
  end

endmodule

// ----- rtl/skt_tree.sv -----
// Registered reduction tree: finds the first slot not below the key, and any match
module skt_tree #(
  parameter int N  = 1024,
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic [N-1:0]  ge,
  input  logic [N-1:0]  eq,
  output logic          root_any,
  output logic          root_hit,
  output logic [CW-1:0] root_idx
);

  localparam int LVL = $clog2(N);
  localparam int P   = 1 << LVL;

  logic [P-1:0]               lany;
  logic [P-1:0]               lhit;
  logic [P-1:0][CW-1:0]       lidx;
  logic [2*P-1:1]             nany;
  logic [2*P-1:1]             nhit;
  logic [2*P-1:1][CW-1:0]     nidx;

  // leaf marks the boundary of the thermometer code
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i == 0) begin : g_first
      assign lany[i] = ge[i];
      assign lhit[i] = eq[i];
    end else if (i < N) begin : g_mid
      assign lany[i] = ge[i] & ~ge[i-1];
      assign lhit[i] = eq[i];
    end else begin : g_pad
      assign lany[i] = 1'b0;
      assign lhit[i] = 1'b0;
    end
    assign lidx[i] = lany[i] ? CW'(i) : '0;
  end

  always_ff @(posedge clk) begin
    nany[2*P-1:P] <= lany;
    nhit[2*P-1:P] <= lhit;
    nidx[2*P-1:P] <= lidx;
    for (int k = 1; k < P; k++) begin
      nany[k] <= nany[2*k] | nany[2*k+1];
      nhit[k] <= nhit[2*k] | nhit[2*k+1];
      nidx[k] <= nidx[2*k] | nidx[2*k+1];
    end
  end

  assign root_any = nany[1];
  assign root_hit = nhit[1];
  assign root_idx = nidx[1];

endmodule

// ----- rtl/skt_checker.sv -----
// Port-level checker for the sorted key table, with its bind
`include "sorted_key_table_find_insert_assert.svh"

module skt_checker import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             func,
  input logic [KEY_W-1:0] vaddr,
  input logic             out_valid,
  input logic             out_ready,
  input logic             hit,
  input logic             inserted,
  input logic             full_res,
  input logic [CW-1:0]    position,
  input logic [CW-1:0]    entry_count
);

  `SKT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(position) && $stable(entry_count) && $stable(hit), "result changed while stalled")
  `SKT_ASSERT_NOW(a_one_outcome, clk, rst, out_valid, $countones({hit, inserted, full_res}) <= 1, "more than one outcome flagged")
  `SKT_ASSERT_NOW(a_pos_in_table, clk, rst, out_valid && (hit || inserted), position < entry_count, "position outside stored entries")
  `SKT_ASSERT_NOW(a_full_count, clk, rst, out_valid && full_res, entry_count == CW'(CAPACITY), "refusal without a full table")

endmodule

bind sorted_key_table_find_insert skt_checker #(.CAPACITY(CAPACITY), .CW(CW)) u_skt_checker (.*);
